// ===== hw/rtl/cft_pkg.sv =====
// cft_pkg: types and character/event codes shared by the csv tokenizer files
// no dependencies
package cft_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_EOF  = 2'd1;
    localparam logic [1:0] EV_EOR  = 2'd2;

    // most results one input word can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] byte_out;
        logic       in_header;
        logic       last;
    } cft_res_t;

    typedef struct packed {
        logic [1:0]         count;
        cft_res_t [2:0]     res;
    } cft_step_t;

endpackage

// ===== hw/rtl/cft_in_if.sv =====
// cft_in_if: input channel of the csv tokenizer (valid/ready plus one input word)
// no dependencies
interface cft_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_in;

    modport source (output valid, output kind, output byte_in, input ready);
    modport sink   (input valid, input kind, input byte_in, output ready);
endinterface

// ===== hw/rtl/cft_out_if.sv =====
// cft_out_if: result channel of the csv tokenizer (valid/ready plus one result word)
// no dependencies
interface cft_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] byte_out;
    logic       in_header;
    logic       last;

    modport source (output valid, output event_res, output byte_out, output in_header,
                    output last, input ready);
    modport sink   (input valid, input event_res, input byte_out, input in_header,
                    input last, output ready);
endinterface

// ===== hw/rtl/csv_field_tokenizer.sv =====
// csv_field_tokenizer: byte-serial csv tokenizer top, uses cft_pkg, cft_parse and the channel ifs
// latency: into an empty queue the first result of a word is shown the cycle after acceptance
// throughput: one input word per cycle while each word gives at most one result and results
//   are taken every cycle; a four-entry queue decouples the sides, input is ready while at
//   most one entry is held or two with a pop
// reset: parser at record start with header flag set, result queue empty
module csv_field_tokenizer
    import cft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cft_in_if.sink    in_chan,
    cft_out_if.source out_chan
);

    localparam int QDEPTH = 4;

    cft_step_t  step;
    cft_res_t   slot_reg  [QDEPTH];
    cft_res_t   slot_next [QDEPTH];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [2:0] base;
    logic       pop;
    logic       accept;

    assign pop    = out_chan.valid && out_chan.ready;
    assign base   = cnt_reg - {2'b00, pop};
    // room for a worst-case word of three results
    assign in_chan.ready = (cnt_reg <= 3'd1) || (cnt_reg == 3'd2 && pop);
    assign accept = in_chan.valid && in_chan.ready;

    cft_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (in_chan.kind),
        .byte_in (in_chan.byte_in),
        .step    (step)
    );

    always_comb
    begin
        logic [2:0] off;
        for (int i = 0; i < QDEPTH; i++)
        begin
            off = 3'(i) - base;
            if (accept && (3'(i) >= base) && (off < {1'b0, step.count}))
            begin
                slot_next[i] = step.res[off[1:0]];
            end
            else if (pop && i < QDEPTH - 1)
            begin
                slot_next[i] = slot_reg[(i + 1) % QDEPTH];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
        end
        cnt_next = base + (accept ? {1'b0, step.count} : 3'd0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign out_chan.valid     = (cnt_reg != 3'd0);
    assign out_chan.event_res = slot_reg[0].event_res;
    assign out_chan.byte_out  = slot_reg[0].byte_out;
    assign out_chan.in_header = slot_reg[0].in_header;
    assign out_chan.last      = slot_reg[0].last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step.count != 2'd0 |=> out_chan.valid)
        else $error("accepted word with results left output idle");

    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step.count != 2'd0 |-> step.res[step.count - 2'd1].last)
        else $error("final result of a word not tagged last");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop && cnt_reg == 3'd1 && !accept |=> !out_chan.valid)
        else $error("queue shows a word after draining");

endmodule

// ===== hw/rtl/cft_parse.sv =====
// cft_parse: parser state and per-byte decode of the csv tokenizer
// depends on cft_pkg
module cft_parse
    import cft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       kind,
    input  logic [7:0] byte_in,
    output cft_step_t  step
);

    localparam logic [3:0] PH_REC      = 4'd0;
    localparam logic [3:0] PH_COMMA    = 4'd1;
    localparam logic [3:0] PH_PRESPACE = 4'd2;
    localparam logic [3:0] PH_UNQ      = 4'd3;
    localparam logic [3:0] PH_QUOTED   = 4'd4;
    localparam logic [3:0] PH_ESC      = 4'd5;
    localparam logic [3:0] PH_CLOSEQ   = 4'd6;
    localparam logic [3:0] PH_POST     = 4'd7;
    localparam logic [3:0] PH_NL       = 4'd8;

    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic       header_reg;
    logic       header_next;

    always_comb
    begin
        logic [1:0] n;
        logic       do_start;
        logic       do_end;
        logic       rec_start;

        n           = 2'd0;
        do_start    = 1'b0;
        do_end      = 1'b0;
        rec_start   = 1'b0;
        phase_next  = phase_reg;
        header_next = header_reg;
        step        = '0;

        if (kind)
        begin
            unique case (phase_reg)
                PH_NL:
                begin
                end
                PH_UNQ, PH_QUOTED:
                begin
                    step.res[n].event_res = EV_EOF;
                    n = n + 2'd1;
                    do_end = 1'b1;
                end
                PH_ESC:
                begin
                    // dangling backslash goes out as a literal
                    step.res[n].event_res = EV_BYTE;
                    step.res[n].byte_out  = CH_BSL;
                    n = n + 2'd1;
                    step.res[n].event_res = EV_EOF;
                    n = n + 2'd1;
                    do_end = 1'b1;
                end
                default:
                begin
                    do_end = 1'b1;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_NL:
                begin
                    if (byte_in != CH_NL)
                    begin
                        rec_start = 1'b1;
                    end
                end
                PH_COMMA, PH_PRESPACE:
                begin
                    priority if (byte_in == CH_NL)
                    begin
                        step.res[n].event_res = EV_EOF;
                        n = n + 2'd1;
                        do_end = 1'b1;
                    end
                    else if (byte_in == CH_COMMA)
                    begin
                        if (phase_reg == PH_PRESPACE)
                        begin
                            step.res[n].event_res = EV_EOF;
                            n = n + 2'd1;
                        end
                        phase_next = PH_COMMA;
                    end
                    else if (byte_in == CH_SPACE)
                    begin
                        phase_next = PH_PRESPACE;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                PH_UNQ:
                begin
                    priority if (byte_in == CH_COMMA)
                    begin
                        step.res[n].event_res = EV_EOF;
                        n = n + 2'd1;
                        phase_next = PH_COMMA;
                    end
                    else if (byte_in == CH_NL)
                    begin
                        step.res[n].event_res = EV_EOF;
                        n = n + 2'd1;
                        do_end = 1'b1;
                    end
                    else
                    begin
                        step.res[n].event_res = EV_BYTE;
                        step.res[n].byte_out  = byte_in;
                        n = n + 2'd1;
                    end
                end
                PH_QUOTED:
                begin
                    priority if (byte_in == CH_QUOTE)
                    begin
                        step.res[n].event_res = EV_EOF;
                        n = n + 2'd1;
                        phase_next = PH_CLOSEQ;
                    end
                    else if (byte_in == CH_BSL)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        step.res[n].event_res = EV_BYTE;
                        step.res[n].byte_out  = byte_in;
                        n = n + 2'd1;
                    end
                end
                PH_ESC:
                begin
                    step.res[n].event_res = EV_BYTE;
                    step.res[n].byte_out  = (byte_in == CH_N) ? CH_NL : byte_in;
                    n = n + 2'd1;
                    phase_next = PH_QUOTED;
                end
                PH_CLOSEQ, PH_POST:
                begin
                    // quote run after the closing quote is dropped
                    priority if (byte_in == CH_QUOTE && phase_reg == PH_CLOSEQ)
                    begin
                    end
                    else if (byte_in == CH_SPACE)
                    begin
                        phase_next = PH_POST;
                    end
                    else if (byte_in == CH_COMMA)
                    begin
                        phase_next = PH_COMMA;
                    end
                    else if (byte_in == CH_NL)
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    rec_start = 1'b1;
                end
            endcase

            if (rec_start)
            begin
                priority if (byte_in == CH_NL)
                begin
                    do_end = 1'b1;
                end
                else if (byte_in == CH_COMMA)
                begin
                    phase_next = PH_COMMA;
                end
                else if (byte_in == CH_SPACE)
                begin
                    phase_next = PH_PRESPACE;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
        end

        if (do_start)
        begin
            if (byte_in == CH_QUOTE)
            begin
                phase_next = PH_QUOTED;
            end
            else
            begin
                step.res[n].event_res = EV_BYTE;
                step.res[n].byte_out  = byte_in;
                n = n + 2'd1;
                phase_next = PH_UNQ;
            end
        end

        if (do_end)
        begin
            step.res[n].event_res = EV_EOR;
            n = n + 2'd1;
            header_next = 1'b0;
            phase_next  = PH_NL;
        end

        // end of stream returns to the reset state
        if (kind)
        begin
            phase_next  = PH_REC;
            header_next = 1'b1;
        end

        for (int i = 0; i < MAX_RES; i++)
        begin
            step.res[i].in_header = header_reg;
        end
        if (n != 2'd0)
        begin
            step.res[n - 2'd1].last = 1'b1;
        end
        step.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_REC;
            header_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
        end
    end

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_NL)
        else $error("parser phase left the used codes");

    a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind |=> phase_reg == PH_REC && header_reg)
        else $error("end of stream did not return parser to reset state");

    a_header_only_falls: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !kind && !header_reg |=> !header_reg)
        else $error("header flag came back without end of stream");

endmodule

// ===== sim/csv_field_tokenizer_test.sv =====
`timescale 1ns / 1ps
// csv_field_tokenizer_test: drives csv byte streams into csv_field_tokenizer and checks
// every result word against a built-in token predictor; depends on cft_pkg, cft_in_if,
// cft_out_if and the tokenizer rtl

module csv_field_tokenizer_test
    import cft_pkg::*;
();

    class token_board;
        typedef enum logic [3:0] {
            AT_RECORD, AFTER_COMMA, LEAD_SPACE, IN_PLAIN, IN_QUOTED,
            AFTER_BSL, CLOSE_QUOTE, TRAIL_SPACE, AFTER_NL
        } scan_phase_e;

        scan_phase_e phase;
        logic        header;
        cft_res_t    step_tokens[$];
        cft_res_t    expected_tokens[$];
        int          mismatches;

        function new();
            phase      = AT_RECORD;
            header     = 1'b1;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void emit(logic [1:0] ev, logic [7:0] ch);
            cft_res_t r;
            r.event_res = ev;
            r.byte_out  = ch;
            r.in_header = header;
            r.last      = 1'b0;
            step_tokens.push_back(r);
        endfunction

        function void close_record();
            emit(EV_EOR, 8'h00);
            header = 1'b0;
            phase  = AFTER_NL;
        endfunction

        function void open_field(logic [7:0] ch);
            if (ch == CH_QUOTE)
                phase = IN_QUOTED;
            else
            begin
                emit(EV_BYTE, ch);
                phase = IN_PLAIN;
            end
        endfunction

        function void record_start(logic [7:0] ch);
            if (ch == CH_NL)
                close_record();
            else if (ch == CH_COMMA)
                phase = AFTER_COMMA;
            else if (ch == CH_SPACE)
                phase = LEAD_SPACE;
            else
                open_field(ch);
        endfunction

        function void scan_char(logic [7:0] ch);
            case (phase)
                AFTER_NL:
                begin
                    if (ch != CH_NL)
                    begin
                        phase = AT_RECORD;
                        record_start(ch);
                    end
                end
                AFTER_COMMA, LEAD_SPACE:
                begin
                    if (ch == CH_NL)
                    begin
                        emit(EV_EOF, 8'h00);
                        close_record();
                    end
                    else if (ch == CH_COMMA)
                    begin
                        // spaces then comma make an empty field, bare commas do not
                        if (phase == LEAD_SPACE)
                            emit(EV_EOF, 8'h00);
                        phase = AFTER_COMMA;
                    end
                    else if (ch == CH_SPACE)
                        phase = LEAD_SPACE;
                    else
                        open_field(ch);
                end
                IN_PLAIN:
                begin
                    if (ch == CH_COMMA)
                    begin
                        emit(EV_EOF, 8'h00);
                        phase = AFTER_COMMA;
                    end
                    else if (ch == CH_NL)
                    begin
                        emit(EV_EOF, 8'h00);
                        close_record();
                    end
                    else
                        emit(EV_BYTE, ch);
                end
                IN_QUOTED:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        emit(EV_EOF, 8'h00);
                        phase = CLOSE_QUOTE;
                    end
                    else if (ch == CH_BSL)
                        phase = AFTER_BSL;
                    else
                        emit(EV_BYTE, ch);
                end
                AFTER_BSL:
                begin
                    emit(EV_BYTE, (ch == CH_N) ? CH_NL : ch);
                    phase = IN_QUOTED;
                end
                CLOSE_QUOTE, TRAIL_SPACE:
                begin
                    // the quote run after a closing quote is dropped, then spaces
                    if (!(ch == CH_QUOTE && phase == CLOSE_QUOTE))
                    begin
                        if (ch == CH_SPACE)
                            phase = TRAIL_SPACE;
                        else if (ch == CH_COMMA)
                            phase = AFTER_COMMA;
                        else if (ch == CH_NL)
                            close_record();
                        else
                            open_field(ch);
                    end
                end
                default:
                begin
                    phase = AT_RECORD;
                    record_start(ch);
                end
            endcase
        endfunction

        function void end_stream();
            case (phase)
                AFTER_NL: ;
                IN_PLAIN, IN_QUOTED:
                begin
                    emit(EV_EOF, 8'h00);
                    close_record();
                end
                AFTER_BSL:
                begin
                    // a dangling backslash comes out as itself
                    emit(EV_BYTE, CH_BSL);
                    emit(EV_EOF, 8'h00);
                    close_record();
                end
                default:
                    close_record();
            endcase
            phase  = AT_RECORD;
            header = 1'b1;
        endfunction

        function void note_word(logic kind, logic [7:0] ch);
            step_tokens.delete();
            if (kind)
                end_stream();
            else
                scan_char(ch);
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_token(cft_res_t got);
            cft_res_t want;
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        "%0t: unexpected result ev=%0d byte=%02h hdr=%0b last=%0b",
                        $realtime, got.event_res, got.byte_out, got.in_header, got.last);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.event_res != want.event_res || got.byte_out != want.byte_out ||
                got.in_header != want.in_header || got.last != want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        {"%0t: mismatch exp ev=%0d byte=%02h hdr=%0b last=%0b, ",
                         "got ev=%0d byte=%02h hdr=%0b last=%0b"},
                        $realtime, want.event_res, want.byte_out, want.in_header, want.last,
                        got.event_res, got.byte_out, got.in_header, got.last);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int RANDOM_WORDS   = 100;
    localparam logic [8:0] END_WORD = 9'h100;

    logic clk;
    logic rst_n;

    cft_in_if  in_chan();
    cft_out_if out_chan();

    csv_field_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    token_board sb = new();

    int  words_sent;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_req;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 25);
    endfunction

    // monitors: input words feed the predictor before results of the same edge are checked
    always @(posedge clk)
    begin
        cft_res_t got;
        if (rst_n)
        begin
            if (in_chan.valid && in_chan.ready)
                sb.note_word(in_chan.kind, in_chan.byte_in);
            if (out_chan.valid && out_chan.ready)
            begin
                got.event_res = out_chan.event_res;
                got.byte_out  = out_chan.byte_out;
                got.in_header = out_chan.in_header;
                got.last      = out_chan.last;
                sb.check_token(got);
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int run;
        int gap;
        out_chan.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                run = $urandom_range(1, 12);
                out_chan.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_chan.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_word(input logic kind, input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_chan.valid   <= 1'b1;
        in_chan.kind    <= kind;
        in_chan.byte_in <= ch;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_word(1'b0, ch);
    endtask

    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do
        begin
            if ($urandom_range(0, 3) == 0)
                ch = 8'($urandom_range(0, 255));
            else
                ch = 8'($urandom_range(8'h21, 8'h7E));
        end
        while (ch == CH_COMMA || ch == CH_NL);
        return ch;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CH_QUOTE || ch == CH_BSL);
        return ch;
    endfunction

    // one well-formed record with random content
    task automatic send_record();
        int nfields;
        int style;
        int len;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
            begin
                send_char(CH_COMMA);
                if ($urandom_range(0, 5) == 0)
                    send_char(CH_COMMA);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_char(CH_SPACE);
            style = $urandom_range(0, 9);
            if (style < 5)
            begin
                len = $urandom_range(1, 5);
                repeat (len) send_char(plain_char());
            end
            else if (style < 9)
            begin
                send_char(CH_QUOTE);
                len = $urandom_range(0, 5);
                repeat (len)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        send_char(CH_BSL);
                        send_char($urandom_range(0, 1) ? CH_N : 8'($urandom_range(0, 255)));
                    end
                    else
                        send_char(quoted_char());
                end
                send_char(CH_QUOTE);
                if ($urandom_range(0, 4) == 0)
                    send_char(CH_QUOTE);
                if ($urandom_range(0, 4) == 0)
                    send_char(CH_SPACE);
            end
        end
        if ($urandom_range(0, 9) == 0)
            send_word(1'b1, 8'($urandom_range(0, 255)));
        else
        begin
            send_char(CH_NL);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_char(CH_NL);
            if ($urandom_range(0, 11) == 0)
                send_word(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_noise();
        logic [7:0] specials [6];
        specials = '{CH_QUOTE, CH_COMMA, CH_NL, CH_SPACE, CH_BSL, CH_N};
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 5))
                0:       send_word(1'b1, 8'($urandom_range(0, 255)));
                1, 2:    send_char(specials[3'($urandom_range(0, 5))]);
                default: send_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        logic [8:0] directed [$];
        bit         hold_done;
        bit         pause_done;
        directed = '{END_WORD, {1'b0, CH_SPACE}, {1'b0, CH_COMMA}, {1'b0, CH_COMMA},
                     {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_SPACE},
                     {1'b0, 8'h78}, {1'b0, CH_COMMA}, {1'b0, CH_NL}, {1'b0, CH_NL},
                     {1'b0, CH_QUOTE}, {1'b0, CH_BSL}, {1'b0, CH_N}, {1'b0, 8'hFF},
                     {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_SPACE}, {1'b0, CH_QUOTE},
                     {1'b0, 8'h00}, {1'b0, CH_BSL}, END_WORD, {1'b0, 8'h61}, {1'b0, CH_NL},
                     END_WORD};
        hold_done       = 1'b0;
        pause_done      = 1'b0;
        words_sent      = 0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        rst_n           = 1'b0;
        in_chan.valid   = 1'b0;
        in_chan.kind    = 1'b0;
        in_chan.byte_in = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i][8], directed[i][7:0]);
        wait_drained();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (!hold_done && words_sent > 30)
            begin
                // result side goes quiet while words keep coming, the queue fills
                hold_req  = 1'b1;
                hold_done = 1'b1;
                no_idle   = 1'b1;
            end
            if (!pause_done && words_sent > 70)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 7) < 6)
                send_record();
            else
                send_noise();
        end
        send_word(1'b1, 8'hA5);
        in_chan.valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cft_pkg.sv
hw/rtl/cft_in_if.sv
hw/rtl/cft_out_if.sv
hw/rtl/cft_parse.sv
hw/rtl/csv_field_tokenizer.sv
sim/csv_field_tokenizer_test.sv
